@@ hw/rtl/pin_message_parser_macros.svh @@
// -----------------------------------------------------------------------------
// pin_message_parser_macros.svh
// Assertion macros used by the checker file of the pin message parser.
// -----------------------------------------------------------------------------
`ifndef PIN_MESSAGE_PARSER_MACROS_SVH
`define PIN_MESSAGE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pmp_pkg.sv @@
// -----------------------------------------------------------------------------
// pmp_pkg
// Types and constants of the pin message parser.
// -----------------------------------------------------------------------------
package pmp_pkg;

  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_ANALOG      = 3'd1,
    CMD_DIGITAL     = 3'd2,
    CMD_PINMODE     = 3'd3,
    CMD_REP_ANALOG  = 3'd4,
    CMD_REP_DIGITAL = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ANALOG      = 3'd0,
    KIND_DIGITAL     = 3'd1,
    KIND_PINMODE     = 3'd2,
    KIND_REP_ANALOG  = 3'd3,
    KIND_REP_DIGITAL = 3'd4,
    KIND_VERSION     = 3'd5
  } kind_e;

  localparam int unsigned EnableWidth = 5;

  // Bit positions in handler_enable
  localparam int unsigned EnAnalog     = 0;
  localparam int unsigned EnDigital    = 1;
  localparam int unsigned EnPinmode    = 2;
  localparam int unsigned EnRepAnalog  = 3;
  localparam int unsigned EnRepDigital = 4;

  // Status byte codes (channel nibble masked off below 0xF0)
  localparam logic [7:0] STAT_ANALOG      = 8'hE0;
  localparam logic [7:0] STAT_DIGITAL     = 8'h90;
  localparam logic [7:0] STAT_PINMODE     = 8'hF4;
  localparam logic [7:0] STAT_REP_ANALOG  = 8'hC0;
  localparam logic [7:0] STAT_REP_DIGITAL = 8'hD0;
  localparam logic [7:0] STAT_VERSION     = 8'hF9;
  localparam logic [3:0] SYS_NIBBLE       = 4'hF;

  typedef struct packed {
    logic [1:0] bytes_left;
    cmd_e       pending;
    logic [3:0] channel;
    logic [6:0] first_data;
  } state_t;

  // Kind sits in the lowest bits; the top level splits it off onto tuser
  typedef struct packed {
    logic [13:0] value;
    logic [6:0]  channel;
    kind_e       kind;
  } event_t;

endpackage

@@ hw/rtl/pmp_decode.sv @@
// -----------------------------------------------------------------------------
// pmp_decode
// Per-byte decode: next parser state and the event a byte completes, if any.
// -----------------------------------------------------------------------------
module pmp_decode (
  input  logic [7:0]                        byte_i,
  input  pmp_pkg::state_t                   state_i,
  input  logic [pmp_pkg::EnableWidth-1:0]   enable_i,
  output pmp_pkg::state_t                   state_o,
  output logic                              evt_valid_o,
  output pmp_pkg::event_t                   evt_o
);

  logic [1:0] left_dec;
  logic [7:0] key;
  logic       enabled;

  assign left_dec = state_i.bytes_left - 2'd1;
  assign key = (byte_i[7:4] == pmp_pkg::SYS_NIBBLE) ? byte_i : {byte_i[7:4], 4'h0};

  always_comb begin
    unique case (state_i.pending)
      pmp_pkg::CMD_ANALOG:      enabled = enable_i[pmp_pkg::EnAnalog];
      pmp_pkg::CMD_DIGITAL:     enabled = enable_i[pmp_pkg::EnDigital];
      pmp_pkg::CMD_PINMODE:     enabled = enable_i[pmp_pkg::EnPinmode];
      pmp_pkg::CMD_REP_ANALOG:  enabled = enable_i[pmp_pkg::EnRepAnalog];
      pmp_pkg::CMD_REP_DIGITAL: enabled = enable_i[pmp_pkg::EnRepDigital];
      default:                  enabled = 1'b0;
    endcase
  end

  always_comb begin
    state_o     = state_i;
    evt_valid_o = 1'b0;
    evt_o.kind    = pmp_pkg::KIND_VERSION;
    evt_o.channel = 7'd0;
    evt_o.value   = 14'd0;

    if ((state_i.bytes_left != 2'd0) && !byte_i[7]) begin
      // data byte of a message in progress
      state_o.bytes_left = left_dec;
      if (left_dec != 2'd0) begin
        state_o.first_data = byte_i[6:0];
      end else begin
        state_o.pending = pmp_pkg::CMD_NONE;
        evt_valid_o     = enabled;
        unique case (state_i.pending)
          pmp_pkg::CMD_ANALOG: begin
            evt_o.kind    = pmp_pkg::KIND_ANALOG;
            evt_o.channel = {3'd0, state_i.channel};
            evt_o.value   = {byte_i[6:0], state_i.first_data};
          end
          pmp_pkg::CMD_DIGITAL: begin
            evt_o.kind    = pmp_pkg::KIND_DIGITAL;
            evt_o.value   = {byte_i[6:0], state_i.first_data};
          end
          pmp_pkg::CMD_PINMODE: begin
            evt_o.kind    = pmp_pkg::KIND_PINMODE;
            evt_o.channel = state_i.first_data;
            evt_o.value   = {7'd0, byte_i[6:0]};
          end
          pmp_pkg::CMD_REP_ANALOG: begin
            evt_o.kind    = pmp_pkg::KIND_REP_ANALOG;
            evt_o.channel = {3'd0, state_i.channel};
            evt_o.value   = {7'd0, byte_i[6:0]};
          end
          default: begin
            evt_o.kind    = pmp_pkg::KIND_REP_DIGITAL;
            evt_o.channel = {3'd0, state_i.channel};
            evt_o.value   = {7'd0, byte_i[6:0]};
          end
        endcase
      end
    end else begin
      // taken as status byte; unknown codes keep the pending command
      if (byte_i[7:4] != pmp_pkg::SYS_NIBBLE) begin
        state_o.channel = byte_i[3:0];
      end
      unique case (key)
        pmp_pkg::STAT_ANALOG: begin
          state_o.bytes_left = 2'd2;
          state_o.pending    = pmp_pkg::CMD_ANALOG;
        end
        pmp_pkg::STAT_DIGITAL: begin
          state_o.bytes_left = 2'd2;
          state_o.pending    = pmp_pkg::CMD_DIGITAL;
        end
        pmp_pkg::STAT_PINMODE: begin
          state_o.bytes_left = 2'd2;
          state_o.pending    = pmp_pkg::CMD_PINMODE;
        end
        pmp_pkg::STAT_REP_ANALOG: begin
          state_o.bytes_left = 2'd1;
          state_o.pending    = pmp_pkg::CMD_REP_ANALOG;
        end
        pmp_pkg::STAT_REP_DIGITAL: begin
          state_o.bytes_left = 2'd1;
          state_o.pending    = pmp_pkg::CMD_REP_DIGITAL;
        end
        pmp_pkg::STAT_VERSION: begin
          evt_valid_o = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/pin_message_parser.sv @@
// -----------------------------------------------------------------------------
// pin_message_parser
// Byte-serial parser for a MIDI-style pin-control stream, one event per
// completed message whose handler is enabled.
// -----------------------------------------------------------------------------
//  channel  | dir | width | contents
//  s_axis   | in  |   8   | received message byte
//  m_axis   | out | 24+3  | tdata: channel, value; tuser: event kind
//  cfg      | in  |   5   | handler enable mask
//
//  One byte per cycle unless a held event stalls it; the decode is a single
//  pass from the input beat into the event register and the parser state.
//  The event beat for an accepted byte appears in the cycle after it.
//  A held event stalls input only while m_axis_tready is low.
//  Reset clears parser state, enable mask and the event valid flag.
// -----------------------------------------------------------------------------
module pin_message_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] event_channel, [20:7] event_value
  output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  input  logic        cfg_we_i,
  input  logic [pmp_pkg::EnableWidth-1:0] cfg_wdata_i
);

  pmp_pkg::state_t state_q, state_d;
  pmp_pkg::event_t evt_q, evt_d;
  logic            evt_valid_d;
  logic            out_valid_q;
  logic [pmp_pkg::EnableWidth-1:0] enable_q;
  logic            s_accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  pmp_decode u_decode (
    .byte_i      (s_axis_tdata),
    .state_i     (state_q),
    .enable_i    (enable_q),
    .state_o     (state_d),
    .evt_valid_o (evt_valid_d),
    .evt_o       (evt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s_accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_accept) begin
      out_valid_q <= evt_valid_d;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold payload until a new event is produced
  always_ff @(posedge clk_i) begin
    if (s_accept && evt_valid_d) begin
      evt_q <= evt_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, evt_q.value, evt_q.channel};
  assign m_axis_tuser  = evt_q.kind;

endmodule

@@ hw/rtl/pmp_checker.sv @@
// -----------------------------------------------------------------------------
// pmp_checker
// Port-level checks of the pin message parser, bound to the top level.
// -----------------------------------------------------------------------------
`include "pin_message_parser_macros.svh"

module pmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic        stall;
  logic        empty;
  logic        kind_ok;
  logic        is_digital;
  logic        is_version;
  logic        chan_zero;
  logic        data_zero;
  logic [26:0] beat;

  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign empty      = !m_axis_tvalid;
  assign kind_ok    = m_axis_tuser <= pmp_pkg::KIND_VERSION;
  assign is_digital = m_axis_tvalid && (m_axis_tuser == pmp_pkg::KIND_DIGITAL);
  assign is_version = m_axis_tvalid && (m_axis_tuser == pmp_pkg::KIND_VERSION);
  assign chan_zero  = m_axis_tdata[6:0] == 7'd0;
  assign data_zero  = m_axis_tdata == 24'd0;
  assign beat       = {m_axis_tuser, m_axis_tdata};

  `PMP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stall, m_axis_tvalid && $stable(beat), "beat moved")
  `PMP_ASSERT_IMP(a_ready_empty, clk_i, rst_ni, empty, s_axis_tready, "input held while empty")
  `PMP_ASSERT_IMP(a_kind_range, clk_i, rst_ni, m_axis_tvalid, kind_ok, "event kind out of range")
  `PMP_ASSERT_IMP(a_digital_chan, clk_i, rst_ni, is_digital, chan_zero, "digital channel nonzero")
  `PMP_ASSERT_IMP(a_version_zero, clk_i, rst_ni, is_version, data_zero, "version payload nonzero")

endmodule

bind pin_message_parser pmp_checker u_pmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ verif/pin_message_parser_test.sv @@
// -----------------------------------------------------------------------------
// pin_message_parser_test
// Drives byte streams into the pin message parser and checks every event beat
// against a cycle-free model of the decoder. A short directed table covers the
// value extremes, each message kind, status bytes that select no command, a
// version request inside a message and a status byte that replaces a message.
// Random traffic follows: mostly well-formed messages with random content,
// some noise bytes and cut-off messages. The handler mask changes between
// phases. The sender and the receiver stall at random, and once the receiver
// holds off long enough to back up the input.
// -----------------------------------------------------------------------------
module pin_message_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pmp_pkg::*;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 8;
  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 300;
  localparam int ItemsPerPhase = 237;
  localparam int NumPhases     = 6;
  localparam int MaxReports    = 10;
  localparam int DrainCycles   = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;  // ev holds the event this byte must produce
    event_t     ev;
  } stim_row_t;

  localparam event_t NoEvent = '0;

  localparam stim_row_t DirectedRows [28] = '{
    '{8'hE3, 1'b0, NoEvent},
    '{8'h00, 1'b0, NoEvent},
    '{8'h00, 1'b1, '{14'd0, 7'd3, KIND_ANALOG}},
    '{8'hEF, 1'b0, NoEvent},
    '{8'h7F, 1'b0, NoEvent},
    '{8'h7F, 1'b1, '{14'd16383, 7'd15, KIND_ANALOG}},
    '{8'h90, 1'b0, NoEvent},
    '{8'h7F, 1'b0, NoEvent},
    '{8'h00, 1'b1, '{14'd127, 7'd0, KIND_DIGITAL}},
    '{8'hF4, 1'b0, NoEvent},
    '{8'h05, 1'b0, NoEvent},
    '{8'h03, 1'b1, '{14'd3, 7'd5, KIND_PINMODE}},
    '{8'hC7, 1'b0, NoEvent},
    '{8'h7F, 1'b1, '{14'd127, 7'd7, KIND_REP_ANALOG}},
    '{8'hD0, 1'b0, NoEvent},
    '{8'h00, 1'b1, '{14'd0, 7'd0, KIND_REP_DIGITAL}},
    // unknown status mid-message moves the channel, version fires at once
    '{8'hE1, 1'b0, NoEvent},
    '{8'h10, 1'b0, NoEvent},
    '{8'hA5, 1'b0, NoEvent},
    '{8'hF9, 1'b1, '{14'd0, 7'd0, KIND_VERSION}},
    '{8'h20, 1'b0, NoEvent},
    // data byte with nothing pending counts as a status byte
    '{8'h45, 1'b0, NoEvent},
    // system reset keeps the message alive, a new status replaces it
    '{8'hC4, 1'b0, NoEvent},
    '{8'hFF, 1'b0, NoEvent},
    '{8'h93, 1'b0, NoEvent},
    '{8'h44, 1'b0, NoEvent},
    '{8'h33, 1'b0, NoEvent},
    '{8'hF0, 1'b0, NoEvent}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;  // [7:0] in_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;        // [6:0] channel, [20:7] value
  logic [2:0]             m_axis_tuser;        // [2:0] kind
  logic                   cfg_we_i      = 1'b0;
  logic [EnableWidth-1:0] cfg_wdata_i   = '0;

  // Decoder model state
  logic [1:0]             msg_left   = '0;
  cmd_e                   msg_cmd    = CMD_NONE;
  logic [3:0]             msg_chan   = '0;
  logic [6:0]             first_byte = '0;
  logic [EnableWidth-1:0] handler_en = '0;

  event_t    expected_events [$];
  stim_row_t cur_row       = '0;
  int        src_idle_pct  = 0;
  int        sink_idle_pct = 0;
  bit        hold_off_req  = 1'b0;
  int        items_sent    = 0;
  int        err_count     = 0;
  int        quiet_cycles  = 0;

  pin_message_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Advance the model by one byte; returns 1 when the byte completes an event
  function automatic bit decode_byte(input logic [7:0] b, output event_t ev);
    logic [7:0] status;
    cmd_e       done_cmd;
    bit         enabled;
    ev = NoEvent;
    if (msg_left != 0 && !b[7]) begin
      msg_left = msg_left - 2'd1;
      if (msg_left != 0) begin
        first_byte = b[6:0];
        return 1'b0;
      end
      done_cmd = msg_cmd;
      msg_cmd  = CMD_NONE;
      case (done_cmd)
        CMD_ANALOG: begin
          enabled = handler_en[EnAnalog];
          ev = '{value: {b[6:0], first_byte}, channel: {3'b0, msg_chan}, kind: KIND_ANALOG};
        end
        CMD_DIGITAL: begin
          enabled = handler_en[EnDigital];
          ev = '{value: {b[6:0], first_byte}, channel: 7'd0, kind: KIND_DIGITAL};
        end
        CMD_PINMODE: begin
          enabled = handler_en[EnPinmode];
          ev = '{value: {7'd0, b[6:0]}, channel: first_byte, kind: KIND_PINMODE};
        end
        CMD_REP_ANALOG: begin
          enabled = handler_en[EnRepAnalog];
          ev = '{value: {7'd0, b[6:0]}, channel: {3'b0, msg_chan}, kind: KIND_REP_ANALOG};
        end
        CMD_REP_DIGITAL: begin
          enabled = handler_en[EnRepDigital];
          ev = '{value: {7'd0, b[6:0]}, channel: {3'b0, msg_chan}, kind: KIND_REP_DIGITAL};
        end
        default: enabled = 1'b0;
      endcase
      return enabled;
    end
    if (b[7:4] != SYS_NIBBLE) begin
      msg_chan = b[3:0];
      status   = {b[7:4], 4'h0};
    end else begin
      status = b;
    end
    case (status)
      STAT_ANALOG: begin
        msg_left = 2'd2;
        msg_cmd  = CMD_ANALOG;
      end
      STAT_DIGITAL: begin
        msg_left = 2'd2;
        msg_cmd  = CMD_DIGITAL;
      end
      STAT_PINMODE: begin
        msg_left = 2'd2;
        msg_cmd  = CMD_PINMODE;
      end
      STAT_REP_ANALOG: begin
        msg_left = 2'd1;
        msg_cmd  = CMD_REP_ANALOG;
      end
      STAT_REP_DIGITAL: begin
        msg_left = 2'd1;
        msg_cmd  = CMD_REP_DIGITAL;
      end
      STAT_VERSION: begin
        ev.kind = KIND_VERSION;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void report_mismatch(input string what, input event_t want,
                                          input event_t got);
    err_count++;
    if (err_count <= MaxReports)
      $display("%0t ns: %s: expected kind %0d ch %0d value %0d, got kind %0d ch %0d value %0d",
               $realtime, what, want.kind, want.channel, want.value,
               got.kind, got.channel, got.value);
  endfunction

  function automatic void check_event(input event_t got);
    event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("event with none pending", NoEvent, got);
      return;
    end
    want = expected_events.pop_front();
    if (got.kind !== want.kind || got.channel !== want.channel || got.value !== want.value)
      report_mismatch("event mismatch", want, got);
  endfunction

  // Sample both handshakes at the rising edge; watchdog on the accept activity
  always @(posedge clk_i) begin : monitor
    event_t predicted;
    bit     fires;
    if (rst_ni) begin
      quiet_cycles++;
      if (cfg_we_i)
        handler_en = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        fires = decode_byte(s_axis_tdata, predicted);
        if (cur_row.typed) begin
          fires     = 1'b1;
          predicted = cur_row.ev;
        end
        if (fires)
          expected_events.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        check_event(event_t'({m_axis_tdata[20:0], m_axis_tuser}));
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("pin_message_parser verification failed");
        $finish;
      end
    end
  end

  // Receiver: random ready, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_byte(input stim_row_t row);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    cur_row = row;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.data;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte('{b, 1'b0, NoEvent});
  endtask

  function automatic logic [7:0] rand_data();
    return 8'($urandom_range(127));
  endfunction

  task automatic send_random_message();
    logic [7:0] chan;
    int         shape;
    chan  = 8'($urandom_range(15));
    shape = $urandom_range(99);
    if (shape < 80) begin
      case ($urandom_range(5))
        0: begin
          send_plain(STAT_ANALOG | chan);
          send_plain(rand_data());
          send_plain(rand_data());
        end
        1: begin
          send_plain(STAT_DIGITAL | chan);
          send_plain(rand_data());
          send_plain(rand_data());
        end
        2: begin
          send_plain(STAT_PINMODE);
          send_plain(rand_data());
          send_plain(rand_data());
        end
        3: begin
          send_plain(STAT_REP_ANALOG | chan);
          send_plain(rand_data());
        end
        4: begin
          send_plain(STAT_REP_DIGITAL | chan);
          send_plain(rand_data());
        end
        default: send_plain(STAT_VERSION);
      endcase
    end else if (shape < 90) begin
      send_plain(8'($urandom_range(255)));
    end else begin
      // cut a two-byte message with an arbitrary status byte
      send_plain(($urandom_range(1) != 0 ? STAT_ANALOG : STAT_DIGITAL) | chan);
      send_plain(rand_data());
      send_plain(8'($urandom_range(255, 128)));
      send_plain(rand_data());
    end
  endtask

  // Drain the pipe, then write the handler mask while the block is idle
  task automatic write_handlers(input logic [EnableWidth-1:0] mask);
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mask;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [EnableWidth-1:0] mask;
    int                     phase_end;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 8;
    sink_idle_pct = 81;
    write_handlers('1);
    foreach (DirectedRows[i])
      send_byte(DirectedRows[i]);

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       mask = 5'h15;
        1:       mask = '0;
        3:       mask = 5'h0A;
        5:       mask = '1;
        default: mask = EnableWidth'($urandom_range(31));
      endcase
      write_handlers(mask);
      case (phase / 2)
        0: begin
          src_idle_pct  = 8;
          sink_idle_pct = 81;
        end
        1: begin
          src_idle_pct  = 81;
          sink_idle_pct = 8;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      // back up the block while the sender keeps offering
      if (phase == NumPhases - 1)
        hold_off_req = 1'b1;
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end)
        send_random_message();
    end

    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (err_count == 0)
      $display("pin_message_parser verification clean");
    else
      $display("pin_message_parser verification failed");
    $finish;
  end

endmodule
